// ----- rtl/ssrf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrf_pkg
// Shared widths, item mode codes and the controller state type for the
// stereo sample ring fifo.
// ----------------------------------------------------------------------------
package ssrf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 11;
   localparam int OFFSET_W = 10;
   localparam int MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE_RIGHT,
      ST_READ_WAIT
   } state_type;

endpackage

// ----- rtl/ssrf_channels.sv -----
// ----------------------------------------------------------------------------
// ssrf channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface ssrf_req_if import ssrf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic [OFFSET_W-1:0]        pair_offset;

   modport source (output valid, mode, left_sample, right_sample, pair_offset,
                   input ready);
   modport sink (input valid, mode, left_sample, right_sample, pair_offset,
                 output ready);
endinterface

interface ssrf_rsp_if import ssrf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       sample_valid;
   logic                       is_full;
   logic [LEVEL_W-1:0]         fill_level;

   modport source (output valid, sample_out, sample_valid, is_full, fill_level,
                   input ready);
   modport sink (input valid, sample_out, sample_valid, is_full, fill_level,
                 output ready);
endinterface

// ----- rtl/ssrf_ram.sv -----
// ----------------------------------------------------------------------------
// ssrf_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ssrf_ram import ssrf_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/stereo_sample_ring_fifo.sv -----
// ----------------------------------------------------------------------------
// stereo_sample_ring_fifo
// Circular sample fifo for a serial dac: pair writes overwrite the oldest
// samples, ticks pop one sample, synchronize keeps a set number of pairs.
// ----------------------------------------------------------------------------
// response: write, synchronize and status items are registered in the cycle
//    after accept; a tick that finds a sample first waits for the memory read
// throughput: a write blocks the next item while its right sample is written
//    (two sample writes on one ram port), a tick with data while its read
//    completes; all other items 1 per cycle while responses are taken
// reset: synchronous; a clearing pass then zeroes the store and accepts no item
module stereo_sample_ring_fifo import ssrf_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic      clock,
   input  logic      reset,
   ssrf_req_if.sink  req_chan,
   ssrf_rsp_if.source rsp_chan
);

   localparam int PW    = $clog2(CAPACITY);
   localparam int FW    = $clog2(CAPACITY + 1);
   localparam int SW    = ((FW > LEVEL_W) ? FW : LEVEL_W) + 1;
   localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
   localparam logic [PW-1:0] LAST_A = PW'(CAPACITY - 1);

   function automatic logic [SW-1:0] wrap_idx(input logic [SW-1:0] v);
      wrap_idx = (v >= CAP_S) ? v - CAP_S : v;
   endfunction

   state_type state_ff, state_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [PW-1:0] right_addr_ff, right_addr_in;
   logic [SAMPLE_W-1:0] right_ff, right_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] sample_out_ff, sample_out_in;
   logic                sample_valid_ff, sample_valid_in;
   logic                is_full_ff, is_full_in;
   logic [LEVEL_W-1:0]  fill_level_ff, fill_level_in;

   logic                accept;
   logic                req_ready;
   logic                is_write, is_tick, is_sync, nonempty;
   logic                wr_en, rd_en;
   logic [PW-1:0]       wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic [SAMPLE_W-1:0] rd_data;

   logic [SW-1:0] ext_rp, ext_fill, head_s, head1_s, keep_s, fill_next_s;

   assign accept   = req_chan.valid && req_ready;
   assign is_write = req_chan.mode == MODE_WRITE;
   assign is_tick  = req_chan.mode == MODE_TICK;
   assign is_sync  = req_chan.mode == MODE_SYNC;
   assign nonempty = fill_ff != '0;

   assign ext_rp   = SW'(rp_ff);
   assign ext_fill = SW'(fill_ff);
   assign head_s   = wrap_idx(ext_rp + ext_fill);
   assign head1_s  = wrap_idx(head_s + SW'(1));

   // kept samples: twice the pair count, capped at capacity
   always_comb begin
      keep_s = SW'({req_chan.pair_offset, 1'b0});
      if (keep_s > CAP_S) begin
         keep_s = CAP_S;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_A) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_write) begin
               state_in = ST_WRITE_RIGHT;
            end else if (accept && is_tick && nonempty) begin
               state_in = ST_READ_WAIT;
            end
         end
         ST_WRITE_RIGHT: state_in = ST_IDLE;
         ST_READ_WAIT:   state_in = ST_IDLE;
         default:        state_in = ST_CLEAR;
      endcase
   end

   // state outputs: handshake and memory ports
   always_comb begin
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      rd_en     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_chan.ready;
            if (accept && is_write) begin
               wr_en   = 1'b1;
               wr_addr = head_s[PW-1:0];
               wr_data = req_chan.left_sample;
            end
            rd_en = accept && is_tick && nonempty;
         end
         ST_WRITE_RIGHT: begin
            wr_en   = 1'b1;
            wr_addr = right_addr_ff;
            wr_data = right_ff;
         end
         ST_READ_WAIT: begin
         end
         default: begin
         end
      endcase
   end

   // pointer, fill and response datapath
   always_comb begin
      rp_in           = rp_ff;
      fill_in         = fill_ff;
      clr_in          = clr_ff;
      right_in        = right_ff;
      right_addr_in   = right_addr_ff;
      rsp_valid_in    = rsp_valid_ff;
      sample_out_in   = sample_out_ff;
      sample_valid_in = sample_valid_ff;
      is_full_in      = is_full_ff;
      fill_level_in   = fill_level_ff;

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + PW'(1);
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         if (is_write) begin
            // drop just enough of the oldest samples to make room for the pair
            if (ext_fill + SW'(2) > CAP_S) begin
               rp_in   = PW'(wrap_idx(ext_rp + ext_fill + SW'(2) - CAP_S));
               fill_in = FW'(CAPACITY);
            end else begin
               fill_in = fill_ff + FW'(2);
            end
            right_in      = req_chan.right_sample;
            right_addr_in = head1_s[PW-1:0];
         end else if (is_tick && nonempty) begin
            rp_in   = PW'(wrap_idx(ext_rp + SW'(1)));
            fill_in = fill_ff - FW'(1);
         end else if (is_sync) begin
            rp_in   = PW'(wrap_idx(head_s + CAP_S - keep_s));
            fill_in = keep_s[FW-1:0];
         end
         fill_next_s     = SW'(fill_in);
         sample_out_in   = '0;
         sample_valid_in = is_tick && nonempty;
         is_full_in      = fill_next_s == CAP_S;
         fill_level_in   = fill_next_s[LEVEL_W-1:0];
         // a tick with data waits for the memory read before showing the item
         rsp_valid_in    = !(is_tick && nonempty);
      end else begin
         fill_next_s = ext_fill;
      end

      if (state_ff == ST_READ_WAIT) begin
         sample_out_in = rd_data;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rp_ff        <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      right_ff        <= right_in;
      right_addr_ff   <= right_addr_in;
      sample_out_ff   <= sample_out_in;
      sample_valid_ff <= sample_valid_in;
      is_full_ff      <= is_full_in;
      fill_level_ff   <= fill_level_in;
   end

   ssrf_ram #(
      .DEPTH (CAPACITY),
      .AW    (PW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_out   = sample_out_ff;
   assign rsp_chan.sample_valid = sample_valid_ff;
   assign rsp_chan.is_full      = is_full_ff;
   assign rsp_chan.fill_level   = fill_level_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAPACITY))
      else $error("fill count above capacity");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ_WAIT |-> !rsp_valid_ff)
      else $error("read returned while output register occupied");

   a_write_full: assert property (@(posedge clock) disable iff (reset)
      accept && is_write && (ext_fill + SW'(2) > CAP_S)
      |=> fill_ff == FW'(CAPACITY) && state_ff == ST_WRITE_RIGHT)
      else $error("overwrite did not leave fifo full");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(state_ff == ST_IDLE && is_tick && nonempty && !rsp_valid_ff
                   && $past(is_write)))
      else $error("item accepted during second sample write");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo sample ring fifo. Drives write, tick,
// synchronize and unused-mode items in bursts. A shadow copy of the sample ring
// predicts every status item, and the bench compares each response field
// against it while the response side stalls on rotating patterns.
// ----------------------------------------------------------------------------
module tb;
   import ssrf_pkg::*;

   localparam int RING_DEPTH = 1024;
   localparam int RANDOM_ITEMS = 1950;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic [OFFSET_W-1:0]        pair_offset;
   } pcm_item_t;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       sample_valid;
      logic                       is_full;
      logic [LEVEL_W-1:0]         fill_level;
   } dac_status_t;

   class ring_tracker;
      logic [SAMPLE_W-1:0] samples [RING_DEPTH];
      int unsigned         rd_ptr;
      int unsigned         held;
      dac_status_t         pending [$];
      int                  errors;

      function new();
         foreach (samples[i]) samples[i] = '0;
         rd_ptr = 0;
         held   = 0;
         errors = 0;
      endfunction

      function void discard(int unsigned n);
         if (n > held) n = held;
         rd_ptr = (rd_ptr + n) % RING_DEPTH;
         held   = held - n;
      endfunction

      function void note_item(pcm_item_t it);
         dac_status_t st;
         int unsigned head;
         int unsigned keep;
         st = '0;
         case (it.mode)
            MODE_WRITE: begin
               // make room for two samples, dropping only what is needed
               if (held + 2 > RING_DEPTH) discard(held + 2 - RING_DEPTH);
               head = (rd_ptr + held) % RING_DEPTH;
               samples[head] = it.left_sample;
               samples[(head + 1) % RING_DEPTH] = it.right_sample;
               held = held + 2;
            end
            MODE_TICK: begin
               if (held > 0) begin
                  st.sample_out   = samples[rd_ptr];
                  st.sample_valid = 1'b1;
                  discard(1);
               end
            end
            MODE_SYNC: begin
               keep = it.pair_offset * 2;
               if (keep > RING_DEPTH) keep = RING_DEPTH;
               head = (rd_ptr + held) % RING_DEPTH;
               // may move back over stale slots when keep exceeds the fill
               rd_ptr = (head + RING_DEPTH - keep) % RING_DEPTH;
               held   = keep;
            end
            default: ;
         endcase
         st.is_full    = (held == RING_DEPTH);
         st.fill_level = LEVEL_W'(held);
         pending.push_back(st);
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void check_status(dac_status_t got);
         dac_status_t want;
         if (pending.size() == 0) begin
            $error("unexpected response item with nothing pending");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.sample_out !== want.sample_out) begin
            $error("sample_out expected %0d actual %0d", want.sample_out, got.sample_out);
            errors++;
         end
         if (got.sample_valid !== want.sample_valid) begin
            $error("sample_valid expected %0b actual %0b", want.sample_valid,
                   got.sample_valid);
            errors++;
         end
         if (got.is_full !== want.is_full) begin
            $error("is_full expected %0b actual %0b", want.is_full, got.is_full);
            errors++;
         end
         if (got.fill_level !== want.fill_level) begin
            $error("fill_level expected %0d actual %0d", want.fill_level, got.fill_level);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ssrf_req_if req_chan ();
   ssrf_rsp_if rsp_chan ();

   stereo_sample_ring_fifo #(.CAPACITY(RING_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ring_tracker tracker = new();

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

   // response side: rotating stall mask, replaced when its random age runs out
   logic [15:0] stall_mask = '1;
   int          pattern_age = 0;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         tracker.check_status({rsp_chan.sample_out, rsp_chan.sample_valid,
                               rsp_chan.is_full, rsp_chan.fill_level});
      end
      if (pattern_age == 0) begin
         pattern_age <= $urandom_range(300, 50);
         if ($urandom_range(3) == 0) begin
            stall_mask <= '1;
         end else begin
            stall_mask <= 16'($urandom) | 16'h8001;
         end
      end else begin
         pattern_age <= pattern_age - 1;
         stall_mask  <= {stall_mask[0], stall_mask[15:1]};
      end
      rsp_chan.ready <= stall_mask[0];
   end

   function automatic pcm_item_t mk(logic [MODE_W-1:0] mode, logic [15:0] l,
                                    logic [15:0] r, logic [OFFSET_W-1:0] off);
      pcm_item_t it;
      it.mode         = mode;
      it.left_sample  = l;
      it.right_sample = r;
      it.pair_offset  = off;
      return it;
   endfunction

   // bias 0 balanced, 1 mostly writes, 2 mostly ticks
   function automatic pcm_item_t make_item(int bias);
      pcm_item_t   it;
      int unsigned roll;
      int          w;
      int          t;
      int          s;
      it.left_sample  = 16'($urandom);
      it.right_sample = 16'($urandom);
      it.pair_offset  = 10'($urandom);
      case (bias)
         1:       begin w = 70; t = 20; s = 7; end
         2:       begin w = 15; t = 75; s = 7; end
         default: begin w = 42; t = 45; s = 9; end
      endcase
      roll = $urandom_range(99);
      if (roll < w) begin
         it.mode = MODE_WRITE;
      end else if (roll < w + t) begin
         it.mode = MODE_TICK;
      end else if (roll < w + t + s) begin
         it.mode = MODE_SYNC;
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: it.pair_offset = 10'($urandom_range(40));
            6, 7:             it.pair_offset = 10'($urandom_range(512));
            8:                it.pair_offset = $urandom_range(1) ? 10'd512 : 10'd511;
            default:          it.pair_offset = 10'($urandom_range(1023));
         endcase
      end else begin
         it.mode = MODE_UNUSED;
      end
      return it;
   endfunction

   task automatic send_item(pcm_item_t it);
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= it.mode;
      req_chan.left_sample  <= it.left_sample;
      req_chan.right_sample <= it.right_sample;
      req_chan.pair_offset  <= it.pair_offset;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tracker.note_item(it);
   endtask

   task automatic hold_off(int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      hold_off(1);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      int bias;
      int seg_left;
      int next_drain;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= MODE_WRITE;
      req_chan.left_sample  <= '0;
      req_chan.right_sample <= '0;
      req_chan.pair_offset  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, unused mode, extremes, overwrite, sync corners
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_UNUSED, 16'hffff, 16'hffff, 10'h3ff));
      send_item(mk(MODE_WRITE,  16'h7fff, 16'h8000, 10'd0));
      send_item(mk(MODE_WRITE,  16'hffff, 16'h0000, 10'h3ff));
      send_item(mk(MODE_WRITE,  16'h5555, 16'haaaa, 10'h155));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'd1));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'd512));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      // one slot free, then completely full
      send_item(mk(MODE_WRITE,  16'h1234, 16'hfedc, 10'd0));
      send_item(mk(MODE_WRITE,  16'h8001, 16'h7ffe, 10'd0));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'h3ff));
      send_item(mk(MODE_UNUSED, 16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'd3));
      send_item(mk(MODE_SYNC,   16'h0000, 16'h0000, 10'd300));
      send_item(mk(MODE_TICK,   16'h0000, 16'h0000, 10'd0));
      send_item(mk(MODE_WRITE,  16'h8000, 16'h7fff, 10'h2aa));
      drain_results();

      sent       = 0;
      bias       = 0;
      seg_left   = $urandom_range(200, 20);
      next_drain = 600;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(7) == 0) burst = $urandom_range(200, 60);
         else burst = $urandom_range(24, 1);
         if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
         repeat (burst) begin
            send_item(make_item(bias));
            sent++;
            seg_left--;
            if (seg_left <= 0) begin
               bias     = $urandom_range(2);
               seg_left = $urandom_range(200, 20);
            end
         end
         if (sent >= next_drain) begin
            drain_results();
            next_drain += 600;
         end else begin
            hold_off($urandom_range(8, 1));
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
